>>> sv/gopd_pkg.sv
// Shared types, command codes and delta helpers for the glyph outline point decoder.
`default_nettype none

package gopd_pkg;

  // top two bits of a command byte
  localparam logic [1:0] CMD_SM    = 2'b00;
  localparam logic [1:0] CMD_QUAD  = 2'b01;
  localparam logic [1:0] CMD_ONE   = 2'b10;
  localparam logic [1:0] CMD_START = 2'b11;

  // single-point sub-modes (bits 5:4 of a 10 command)
  localparam logic [1:0] ONE_NIB_X = 2'd0;
  localparam logic [1:0] ONE_NIB_Y = 2'd1;

  // run kinds: quadrants 0..3, sign-magnitude nibbles
  localparam logic [2:0] KIND_SM = 3'd4;

  localparam logic [1:0] QUAD_PP = 2'd0;
  localparam logic [1:0] QUAD_MP = 2'd1;
  localparam logic [1:0] QUAD_PM = 2'd3;

  // result queue sizing
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       truncated;
    logic       glyph_end;
    logic       contour_end;
    logic       point_valid;
    logic [7:0] point_y;
    logic [7:0] point_x;
  } res_t;

  // up to two results per accepted byte, packed from slot a
  typedef struct packed {
    logic [1:0] n;
    res_t       b;
    res_t       a;
  } push_t;

  // sign-magnitude nibble: bit 3 set subtracts the low 3 bits
  function automatic logic [7:0] sm4(input logic [3:0] n);
    logic [7:0] r;
    if (n[3]) r = 8'd0 - {5'd0, n[2:0]};
    else      r = {4'd0, n};
    return r;
  endfunction

  // sign-magnitude byte: bit 7 set subtracts the low 7 bits
  function automatic logic [7:0] sm8(input logic [7:0] n);
    logic [7:0] r;
    if (n[7]) r = 8'd0 - {1'b0, n[6:0]};
    else      r = n;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/gopd_front.sv
// Front end: parses outline bytes, tracks position and the held point, emits results.
`default_nettype none

module gopd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire logic [7:0]     source_byte,
  input  wire logic           last_byte,
  output gopd_pkg::push_t     push
);

  typedef enum logic [2:0] {
    PH_CMD, PH_START2, PH_RUN, PH_ONE_Y, PH_ONE_X, PH_TWO_X, PH_TWO_Y
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  cur_x_r, cur_x_nxt;
  logic [7:0]  cur_y_r, cur_y_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [5:0]  run_rem_r, run_rem_nxt;
  logic [2:0]  run_kind_r, run_kind_nxt;
  logic [7:0]  pend_x_r, pend_x_nxt;
  logic [7:0]  pend_y_r, pend_y_nxt;
  logic        pend_v_r, pend_v_nxt;

  logic        newpt, start;
  logic [7:0]  dx, dy;
  gopd_pkg::res_t pushed, fin;

  always_comb begin
    phase_nxt    = phase_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    held_nxt     = held_r;
    run_rem_nxt  = run_rem_r;
    run_kind_nxt = run_kind_r;
    newpt        = 1'b0;
    start        = 1'b0;
    dx           = {4'd0, source_byte[7:4]};
    dy           = {4'd0, source_byte[3:0]};

    unique case (phase_r)
      PH_START2: begin
        cur_x_nxt = {1'b0, held_r[5:0], source_byte[7]};
        cur_y_nxt = {1'b0, source_byte[6:0]};
        newpt     = 1'b1;
        start     = 1'b1;
        phase_nxt = PH_CMD;
      end
      PH_RUN: begin
        if (run_kind_r == gopd_pkg::KIND_SM) begin
          cur_x_nxt = cur_x_r + gopd_pkg::sm4(source_byte[7:4]);
          cur_y_nxt = cur_y_r + gopd_pkg::sm4(source_byte[3:0]);
        end else begin
          if (run_kind_r[1:0] == gopd_pkg::QUAD_PP || run_kind_r[1:0] == gopd_pkg::QUAD_PM)
            cur_x_nxt = cur_x_r + dx;
          else
            cur_x_nxt = cur_x_r - dx;
          if (run_kind_r[1:0] == gopd_pkg::QUAD_PP || run_kind_r[1:0] == gopd_pkg::QUAD_MP)
            cur_y_nxt = cur_y_r + dy;
          else
            cur_y_nxt = cur_y_r - dy;
        end
        newpt       = 1'b1;
        run_rem_nxt = run_rem_r - 6'd1;
        if (run_rem_nxt == 6'd0) phase_nxt = PH_CMD;
      end
      PH_ONE_Y: begin
        cur_x_nxt = cur_x_r + gopd_pkg::sm4(held_r[3:0]);
        cur_y_nxt = cur_y_r + gopd_pkg::sm8(source_byte);
        newpt     = 1'b1;
        phase_nxt = PH_CMD;
      end
      PH_ONE_X: begin
        cur_x_nxt = cur_x_r + gopd_pkg::sm8(source_byte);
        cur_y_nxt = cur_y_r + gopd_pkg::sm4(held_r[3:0]);
        newpt     = 1'b1;
        phase_nxt = PH_CMD;
      end
      PH_TWO_X: begin
        held_nxt  = source_byte;
        phase_nxt = PH_TWO_Y;
      end
      PH_TWO_Y: begin
        cur_x_nxt = cur_x_r + gopd_pkg::sm8(held_r);
        cur_y_nxt = cur_y_r + gopd_pkg::sm8(source_byte);
        newpt     = 1'b1;
        phase_nxt = PH_CMD;
      end
      default: begin
        // command byte; the unused phase code lands here too
        unique case (source_byte[7:6])
          gopd_pkg::CMD_START: begin
            held_nxt  = source_byte;
            phase_nxt = PH_START2;
          end
          gopd_pkg::CMD_QUAD: begin
            run_kind_nxt = {1'b0, source_byte[5:4]};
            run_rem_nxt  = {2'b00, source_byte[3:0]};
            phase_nxt    = (source_byte[3:0] != 4'd0) ? PH_RUN : PH_CMD;
          end
          gopd_pkg::CMD_SM: begin
            run_kind_nxt = gopd_pkg::KIND_SM;
            run_rem_nxt  = source_byte[5:0];
            phase_nxt    = (source_byte[5:0] != 6'd0) ? PH_RUN : PH_CMD;
          end
          default: begin
            held_nxt = {4'd0, source_byte[3:0]};
            unique case (source_byte[5:4]) inside
              gopd_pkg::ONE_NIB_X: phase_nxt = PH_ONE_Y;
              gopd_pkg::ONE_NIB_Y: phase_nxt = PH_ONE_X;
              default:             phase_nxt = PH_TWO_X;
            endcase
          end
        endcase
      end
    endcase

    pend_x_nxt = pend_x_r;
    pend_y_nxt = pend_y_r;
    pend_v_nxt = pend_v_r;
    if (newpt) begin
      pend_x_nxt = cur_x_nxt;
      pend_y_nxt = cur_y_nxt;
      pend_v_nxt = 1'b1;
    end

    pushed = '{truncated: 1'b0, glyph_end: 1'b0, contour_end: start,
               point_valid: 1'b1, point_y: pend_y_r, point_x: pend_x_r};

    fin.truncated   = (phase_nxt != PH_CMD);
    fin.glyph_end   = 1'b1;
    fin.contour_end = pend_v_nxt;
    fin.point_valid = pend_v_nxt;
    fin.point_y     = pend_v_nxt ? pend_y_nxt : 8'd0;
    fin.point_x     = pend_v_nxt ? pend_x_nxt : 8'd0;

    push.a = pushed;
    push.b = fin;
    push.n = 2'd0;
    if (accept) begin
      if (newpt && pend_v_r) begin
        push.n = last_byte ? 2'd2 : 2'd1;
      end else if (last_byte) begin
        push.a = fin;
        push.n = 2'd1;
      end
    end

    // glyph end: everything back to its reset values
    if (last_byte) begin
      phase_nxt    = PH_CMD;
      cur_x_nxt    = 8'd0;
      cur_y_nxt    = 8'd0;
      held_nxt     = 8'd0;
      run_rem_nxt  = 6'd0;
      run_kind_nxt = 3'd0;
      pend_x_nxt   = 8'd0;
      pend_y_nxt   = 8'd0;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CMD;
      cur_x_r    <= 8'd0;
      cur_y_r    <= 8'd0;
      held_r     <= 8'd0;
      run_rem_r  <= 6'd0;
      run_kind_r <= 3'd0;
      pend_x_r   <= 8'd0;
      pend_y_r   <= 8'd0;
      pend_v_r   <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      cur_x_r    <= cur_x_nxt;
      cur_y_r    <= cur_y_nxt;
      held_r     <= held_nxt;
      run_rem_r  <= run_rem_nxt;
      run_kind_r <= run_kind_nxt;
      pend_x_r   <= pend_x_nxt;
      pend_y_r   <= pend_y_nxt;
      pend_v_r   <= pend_v_nxt;
    end
  end

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_byte |-> push.n != 2'd0)
    else $error("glyph end byte produced no result");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_byte |=> !pend_v_r && phase_r == PH_CMD)
    else $error("state not cleared after glyph end");

  a_two_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> accept && last_byte && push.b.glyph_end)
    else $error("two results without glyph end");

endmodule

`default_nettype wire

>>> sv/gopd_queue.sv
// Result queue: takes up to two results a cycle from the front end, hands out one.
`default_nettype none

module gopd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire gopd_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output gopd_pkg::res_t      out_res
);

  gopd_pkg::res_t                mem_r [gopd_pkg::QDEPTH];
  logic [gopd_pkg::QAW-1:0]      wptr_r, rptr_r;
  logic [gopd_pkg::QAW-1:0]      wptr_p1;
  logic [gopd_pkg::QCW-1:0]      count_r, count_nxt;
  logic                          pop;

  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rptr_r];
  assign pop       = out_valid && out_ready;
  // front may push two results, so keep two slots free
  assign room      = (count_r <= gopd_pkg::QCW'(gopd_pkg::QDEPTH - 2));
  assign wptr_p1   = wptr_r + 1'b1;

  assign count_nxt = count_r + gopd_pkg::QCW'(push.n) - gopd_pkg::QCW'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wptr_r] <= push.a;
    if (push.n == 2'd2) mem_r[wptr_p1] <= push.b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_r + gopd_pkg::QAW'(push.n);
      rptr_r  <= rptr_r + gopd_pkg::QAW'(pop);
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> count_r <= gopd_pkg::QCW'(gopd_pkg::QDEPTH - 2))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= gopd_pkg::QCW'(gopd_pkg::QDEPTH))
    else $error("result queue count out of range");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("waiting result changed or dropped");

endmodule

`default_nettype wire

>>> sv/glyph_outline_point_decoder.sv
// Top level of the glyph outline point decoder: byte stream in, point stream out.
`default_nettype none

// Takes one outline byte per cycle and emits decoded points. The front end
// parses the byte and updates position in the same cycle; results are
// registered in a four-entry queue that feeds the output. Most bytes give
// zero or one result; a glyph's final byte may give two (the held point
// and the glyph end). in_tready drops when fewer than two queue slots are
// free, so with the output taking every cycle the input sustains one byte
// per cycle.

module glyph_outline_point_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] source_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] point_x, [15:8] point_y
  output logic [2:0]       out_tuser,  // [0] point_valid, [1] contour_end, [2] truncated
  output logic             out_tlast   // glyph_end
);

  gopd_pkg::push_t push;
  gopd_pkg::res_t  res;
  logic            accept;

  assign accept = in_tvalid && in_tready;

  gopd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .source_byte (in_tdata),
    .last_byte   (in_tlast),
    .push        (push)
  );

  gopd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {res.point_y, res.point_x};
  assign out_tuser = {res.truncated, res.contour_end, res.point_valid};
  assign out_tlast = res.glyph_end;

endmodule

`default_nettype wire
